### hw/rtl/stream_substring_replace_defines.svh
// Assertion macros for the stream_substring_replace checker.
// Both expect clk and arst_n in scope.
`ifndef STREAM_SUBSTRING_REPLACE_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACE_DEFINES_SVH

// same-cycle implication
`define SSR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssr check failed: same-cycle rule");

// next-cycle implication
`define SSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssr check failed: next-cycle rule");

`endif

### hw/rtl/ssr_pkg.sv
package ssr_pkg;

	localparam int BYTE_W    = 8;
	localparam int PAT_BYTES = 6;
	localparam int REP_BYTES = 8;
	localparam int PLEN_W    = 3;
	localparam int RLEN_W    = 4;
	localparam int CNT_W     = 4;
	localparam int CFG_W     = 64;
	localparam int IDX_W     = 2;

	localparam logic [PAT_BYTES*BYTE_W-1:0] PATTERN_RST     = 48'd107105419094343;
	localparam logic [PLEN_W-1:0]           PLEN_RST        = 3'd6;
	localparam logic [REP_BYTES*BYTE_W-1:0] REPLACEMENT_RST = 64'd7020108417744726343;
	localparam logic [RLEN_W-1:0]           RLEN_RST        = 4'd8;

	typedef enum logic [IDX_W-1:0] {
		REG_PATTERN  = 2'd0,
		REG_PLEN     = 2'd1,
		REG_REPLACE  = 2'd2,
		REG_RLEN     = 2'd3
	} cfg_reg_t;

	// broadcast to every window cell
	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              en;
		logic              shift;
		logic              clear;
	} cell_ctl_t;

	// group of output bytes caused by one item
	typedef struct packed {
		logic [REP_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]                 cnt;
		logic                             eos;
	} burst_t;

	function automatic logic [PLEN_W-1:0] clamp_plen(input logic [PLEN_W-1:0] v);
		logic [PLEN_W-1:0] r;
		if (v == '0) begin
			r = PLEN_W'(1);
		end else if (v > PLEN_W'(PAT_BYTES)) begin
			r = PLEN_W'(PAT_BYTES);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [RLEN_W-1:0] clamp_rlen(input logic [RLEN_W-1:0] v);
		logic [RLEN_W-1:0] r;
		if (v == '0) begin
			r = RLEN_W'(1);
		end else if (v > RLEN_W'(REP_BYTES)) begin
			r = RLEN_W'(REP_BYTES);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### hw/rtl/ssr_cell.sv
// One window byte: takes the new byte when selected, compares with its pattern byte,
// shifts from its neighbour on a miss.
module ssr_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ssr_pkg::cell_ctl_t             ctl,
	input  logic                           sel,
	input  logic [ssr_pkg::BYTE_W-1:0]     pat,
	input  logic [ssr_pkg::BYTE_W-1:0]     nbr,
	output logic [ssr_pkg::BYTE_W-1:0]     cur,
	output logic                           hit
);

	logic [ssr_pkg::BYTE_W-1:0] byte_q;

	assign cur = sel ? ctl.ch : byte_q;
	assign hit = (cur == pat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.en) begin
			byte_q <= ctl.shift ? nbr : cur;
		end
	end

endmodule

### hw/rtl/ssr_serial.sv
// Output serialiser: holds one burst, hands out a byte per accepted result.
module ssr_serial (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load_valid,
	output logic                           load_ready,
	input  ssr_pkg::burst_t                load,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ssr_pkg::BYTE_W-1:0]     char_out,
	output logic                           run_last,
	output logic                           string_end
);

	logic [ssr_pkg::REP_BYTES-1:0][ssr_pkg::BYTE_W-1:0] buf_q;
	logic [ssr_pkg::CNT_W-1:0]                          cnt_q;
	logic                                               eos_q;
	logic                                               fire;
	logic                                               last;

	assign last       = (cnt_q == ssr_pkg::CNT_W'(1));
	assign out_valid  = (cnt_q != '0);
	assign fire       = out_valid && out_ready;
	assign load_ready = !out_valid || (last && out_ready);
	assign char_out   = buf_q[0];
	assign run_last   = last;
	assign string_end = last && eos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			eos_q <= 1'b0;
		end else if (load_valid && load_ready) begin
			cnt_q <= load.cnt;
			eos_q <= load.eos;
		end else if (fire) begin
			cnt_q <= cnt_q - ssr_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			buf_q <= load.bytes;
		end else if (fire) begin
			buf_q <= {ssr_pkg::BYTE_W'(0), buf_q[ssr_pkg::REP_BYTES-1:1]};
		end
	end

endmodule

### hw/rtl/stream_substring_replace.sv
// Streaming fixed-string find and replace.
// Input channel (in_valid/in_ready): one text byte per item, char_in, with
// end_of_string set on the last byte of a string. Output channel
// (out_valid/out_ready): one rewritten byte per item, char_out; run_last marks
// the last byte caused by one input item, string_end the final byte of a string.
// Configuration: cfg_we/cfg_index/cfg_data write pattern, pattern length,
// replacement and replacement length; write only while the block is idle.
// Writing the pattern length drops any bytes held in the window.
// A result passes from its accepted item through the burst register, then the
// output serialiser, before it shows on the output.
// Throughput: one item per cycle while each item causes at most one byte and
// the receiver does not stall; an item causing more bytes holds the serialiser
// until all are out, up to eight on a match. Its byte count sets the rate.
// The burst register lets one item be taken while the serialiser still waits.
// A receiver stall simply holds the output byte; input backs up once the burst
// register is also full. Reset empties the window and both output stages and
// loads the default pattern, replacement and both lengths.
module stream_substring_replace (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [ssr_pkg::IDX_W-1:0]              cfg_index,
	input  logic [ssr_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ssr_pkg::BYTE_W-1:0]             char_in,
	input  logic                                   end_of_string,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [ssr_pkg::BYTE_W-1:0]             char_out,
	output logic                                   run_last,
	output logic                                   string_end
);

	// configuration registers
	logic [ssr_pkg::PAT_BYTES*ssr_pkg::BYTE_W-1:0] pattern_q;
	logic [ssr_pkg::PLEN_W-1:0]                    plen_q;
	logic [ssr_pkg::REP_BYTES*ssr_pkg::BYTE_W-1:0] replace_q;
	logic [ssr_pkg::RLEN_W-1:0]                    rlen_q;

	logic [ssr_pkg::PLEN_W-1:0] plen;
	logic [ssr_pkg::RLEN_W-1:0] rlen;

	// window bookkeeping
	logic [ssr_pkg::PLEN_W-1:0] fill_q;
	logic [ssr_pkg::PLEN_W-1:0] fill_eff;
	logic [ssr_pkg::PLEN_W-1:0] fill_app;
	logic                       full;
	logic                       match;
	logic                       in_fire;
	logic                       plen_wr;

	ssr_pkg::cell_ctl_t         ctl;
	logic [ssr_pkg::BYTE_W-1:0] cur [ssr_pkg::PAT_BYTES];
	logic [ssr_pkg::BYTE_W-1:0] nbr [ssr_pkg::PAT_BYTES];
	logic [ssr_pkg::PAT_BYTES-1:0] hit_vec;
	logic [ssr_pkg::PAT_BYTES-1:0] sel_vec;
	logic [ssr_pkg::PAT_BYTES-1:0] pmask;

	// burst register between window and serialiser
	ssr_pkg::burst_t burst;
	ssr_pkg::burst_t burst_s1;
	logic            burst_valid_s1;
	logic            load_ready;

	assign plen = ssr_pkg::clamp_plen(plen_q);
	assign rlen = ssr_pkg::clamp_rlen(rlen_q);

	assign plen_wr = cfg_we && (cfg_index == ssr_pkg::REG_PLEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= ssr_pkg::PATTERN_RST;
			plen_q    <= ssr_pkg::PLEN_RST;
			replace_q <= ssr_pkg::REPLACEMENT_RST;
			rlen_q    <= ssr_pkg::RLEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ssr_pkg::REG_PATTERN: begin
					pattern_q <= cfg_data[ssr_pkg::PAT_BYTES*ssr_pkg::BYTE_W-1:0];
				end
				ssr_pkg::REG_PLEN: begin
					plen_q <= cfg_data[ssr_pkg::PLEN_W-1:0];
				end
				ssr_pkg::REG_REPLACE: begin
					replace_q <= cfg_data[ssr_pkg::REP_BYTES*ssr_pkg::BYTE_W-1:0];
				end
				ssr_pkg::REG_RLEN: begin
					rlen_q <= cfg_data[ssr_pkg::RLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// fill stays below plen between items; guard anyway
	assign fill_eff = (fill_q >= plen) ? (plen - ssr_pkg::PLEN_W'(1)) : fill_q;
	assign fill_app = fill_eff + ssr_pkg::PLEN_W'(1);
	assign full     = (fill_app == plen);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		for (int k = 0; k < ssr_pkg::PAT_BYTES; k++) begin
			pmask[k]   = (ssr_pkg::PLEN_W'(k) < plen);
			sel_vec[k] = (fill_eff == ssr_pkg::PLEN_W'(k));
		end
	end

	// only the first plen cells take part in the compare
	assign match = full && (&(hit_vec | ~pmask));

	assign ctl.ch    = char_in;
	assign ctl.en    = in_fire;
	assign ctl.shift = full && !match;
	assign ctl.clear = plen_wr || (in_fire && (match || end_of_string));

	// row of window cells, oldest byte in cell 0
	for (genvar g = 0; g < ssr_pkg::PAT_BYTES; g++) begin : g_cell
		if (g == ssr_pkg::PAT_BYTES - 1) begin : g_tail
			assign nbr[g] = '0;
		end else begin : g_mid
			assign nbr[g] = cur[g+1];
		end

		ssr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sel    (sel_vec[g]),
			.pat    (pattern_q[g*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W]),
			.nbr    (nbr[g]),
			.cur    (cur[g]),
			.hit    (hit_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (plen_wr) begin
			fill_q <= '0;
		end else if (in_fire) begin
			if (match || end_of_string) begin
				fill_q <= '0;
			end else if (full) begin
				fill_q <= plen - ssr_pkg::PLEN_W'(1);
			end else begin
				fill_q <= fill_app;
			end
		end
	end

	// bytes caused by this item: the replacement on a match, otherwise the
	// window front (one byte on a miss, none while filling, the whole rest at end of string)
	always_comb begin
		burst.bytes = '0;
		burst.eos   = end_of_string;
		if (match) begin
			for (int k = 0; k < ssr_pkg::REP_BYTES; k++) begin
				burst.bytes[k] = replace_q[k*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W];
			end
			burst.cnt = ssr_pkg::CNT_W'(rlen);
		end else begin
			for (int k = 0; k < ssr_pkg::PAT_BYTES; k++) begin
				burst.bytes[k] = cur[k];
			end
			if (end_of_string) begin
				burst.cnt = ssr_pkg::CNT_W'(fill_app);
			end else if (full) begin
				burst.cnt = ssr_pkg::CNT_W'(1);
			end else begin
				burst.cnt = '0;
			end
		end
	end

	assign in_ready = !burst_valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_s1 <= 1'b0;
		end else if (in_fire && (burst.cnt != '0)) begin
			burst_valid_s1 <= 1'b1;
		end else if (load_ready) begin
			burst_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (burst.cnt != '0)) begin
			burst_s1 <= burst;
		end
	end

	ssr_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (burst_valid_s1),
		.load_ready (load_ready),
		.load       (burst_s1),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_out   (char_out),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

### hw/rtl/ssr_checker.sv
`include "stream_substring_replace_defines.svh"

// Port-level checks on the output side and on in_ready.
module ssr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ssr_pkg::BYTE_W-1:0] char_out,
	input logic                       run_last,
	input logic                       string_end
);

	// end of a string always closes the run of its item
	`SSR_ASSERT_NOW(a_end_is_last, out_valid && string_end, run_last)

	// with nothing on the output, nothing can be backed up at the input
	`SSR_ASSERT_NOW(a_idle_ready, !out_valid, in_ready)

	// a stalled byte holds
	`SSR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(char_out) && $stable(run_last) && $stable(string_end))

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.char_out   (char_out),
	.run_last   (run_last),
	.string_end (string_end)
);

### tb/tb_stream_substring_replace.sv
module tb_stream_substring_replace;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 200;
	localparam int SETTLE_CYCLES  = 8;    // well past the two-stage output latency
	localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000; // cycles without any handshake or write
	localparam int MAX_REPORTS    = 10;

	// one rewritten byte as it should leave the block
	typedef struct packed {
		logic [ssr_pkg::BYTE_W-1:0] ch;
		logic                       run_last;
		logic                       string_end;
	} text_byte_t;

	typedef logic [ssr_pkg::BYTE_W-1:0] text_q_t [$];

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic                             cfg_we        = 1'b0;
	logic [ssr_pkg::IDX_W-1:0]        cfg_index     = '0;
	logic [ssr_pkg::CFG_W-1:0]        cfg_data      = '0;
	logic                             in_valid      = 1'b0;
	logic                             in_ready;
	logic [ssr_pkg::BYTE_W-1:0]       char_in       = '0;
	logic                             end_of_string = 1'b0;
	logic                             out_valid;
	logic                             out_ready     = 1'b0;
	logic [ssr_pkg::BYTE_W-1:0]       char_out;
	logic                             run_last;
	logic                             string_end;

	stream_substring_replace dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_in       (char_in),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_out      (char_out),
		.run_last      (run_last),
		.string_end    (string_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: own copy of the registers and the undecided window
	// ------------------------------------------------------------------
	logic [ssr_pkg::PAT_BYTES*ssr_pkg::BYTE_W-1:0] pat_model  = ssr_pkg::PATTERN_RST;
	logic [ssr_pkg::PLEN_W-1:0]                    plen_model = ssr_pkg::PLEN_RST;
	logic [ssr_pkg::REP_BYTES*ssr_pkg::BYTE_W-1:0] rep_model  = ssr_pkg::REPLACEMENT_RST;
	logic [ssr_pkg::RLEN_W-1:0]                    rlen_model = ssr_pkg::RLEN_RST;
	logic [ssr_pkg::BYTE_W-1:0] window_model [ssr_pkg::PAT_BYTES] = '{default: '0};
	int                         window_fill = 0;

	text_byte_t rewritten_q [$]; // bytes still owed by the block, oldest first
	int         items_sent  = 0;
	int         mismatches  = 0;

	// out-of-range lengths: zero acts as one, oversize saturates
	function automatic int eff_plen();
		if (plen_model == '0) begin
			return 1;
		end
		return (plen_model > ssr_pkg::PAT_BYTES) ? ssr_pkg::PAT_BYTES : int'(plen_model);
	endfunction

	function automatic int eff_rlen();
		if (rlen_model == '0) begin
			return 1;
		end
		return (rlen_model > ssr_pkg::REP_BYTES) ? ssr_pkg::REP_BYTES : int'(rlen_model);
	endfunction

	function automatic void clear_window();
		foreach (window_model[k]) begin
			window_model[k] = '0;
		end
		window_fill = 0;
	endfunction

	// Advance the window by one accepted item and queue the bytes it releases.
	function automatic void rewrite_byte(input logic [ssr_pkg::BYTE_W-1:0] c,
	                                     input logic eos);
		text_byte_t run [$];
		int         plen;
		int         rlen;
		bit         hit;
		plen = eff_plen();
		rlen = eff_rlen();
		if (window_fill >= plen) begin
			window_fill = plen - 1;
		end
		window_model[window_fill] = c;
		window_fill++;
		if (window_fill == plen) begin
			hit = 1'b1;
			for (int k = 0; k < plen; k++) begin
				if (window_model[k] != pat_model[8*k +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				for (int k = 0; k < rlen; k++) begin
					run.push_back('{ch: rep_model[8*k +: 8], run_last: 1'b0, string_end: 1'b0});
				end
				clear_window();
			end else begin
				// no match: oldest byte leaves, the rest slide down
				run.push_back('{ch: window_model[0], run_last: 1'b0, string_end: 1'b0});
				for (int k = 0; k < ssr_pkg::PAT_BYTES - 1; k++) begin
					window_model[k] = window_model[k+1];
				end
				window_model[ssr_pkg::PAT_BYTES-1] = '0;
				window_fill--;
			end
		end
		// last byte of the string flushes whatever is still undecided
		if (eos) begin
			for (int k = 0; k < window_fill; k++) begin
				run.push_back('{ch: window_model[k], run_last: 1'b0, string_end: 1'b0});
			end
			clear_window();
		end
		if (run.size() > 0) begin
			run[run.size()-1].run_last   = 1'b1;
			run[run.size()-1].string_end = eos;
		end
		foreach (run[k]) begin
			rewritten_q.push_back(run[k]);
		end
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of random length, random gaps between them
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic send_item(input logic [ssr_pkg::BYTE_W-1:0] c, input logic eos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid      <= 1'b1;
		char_in       <= c;
		end_of_string <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		rewrite_byte(c, eos);
	endtask

	// ends: mark the final byte as end of string (off for strings split by a write)
	task automatic send_text(input text_q_t text, input bit ends);
		foreach (text[k]) begin
			send_item(text[k], ends && (k == text.size() - 1));
		end
	endtask

	// Sender pauses until every owed byte is out, then lets the pipe go quiet;
	// an item that releases nothing may still be in flight otherwise.
	task automatic settle();
		in_valid <= 1'b0;
		while (rewritten_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// strobe drops once the write edge has passed, so no step sees two drives
	task automatic write_reg(input ssr_pkg::cfg_reg_t idx,
	                         input logic [ssr_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			ssr_pkg::REG_PATTERN: begin
				pat_model = data[ssr_pkg::PAT_BYTES*ssr_pkg::BYTE_W-1:0];
			end
			ssr_pkg::REG_PLEN: begin
				plen_model = data[ssr_pkg::PLEN_W-1:0];
				clear_window(); // held bytes are dropped, never emitted
			end
			ssr_pkg::REG_REPLACE: rep_model  = data;
			ssr_pkg::REG_RLEN:    rlen_model = data[ssr_pkg::RLEN_W-1:0];
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [ssr_pkg::CFG_W-1:0] pat,
	                         input logic [ssr_pkg::CFG_W-1:0] plen,
	                         input logic [ssr_pkg::CFG_W-1:0] rep,
	                         input logic [ssr_pkg::CFG_W-1:0] rlen);
		settle();
		write_reg(ssr_pkg::REG_PATTERN, pat);
		write_reg(ssr_pkg::REG_PLEN, plen);
		write_reg(ssr_pkg::REG_REPLACE, rep);
		write_reg(ssr_pkg::REG_RLEN, rlen);
	endtask

	function automatic text_q_t pattern_text(input int n);
		text_q_t t;
		for (int k = 0; k < n; k++) begin
			t.push_back(pat_model[8*k +: 8]);
		end
		return t;
	endfunction

	// Mostly well-formed: whole patterns, cut-off patterns, patterns with one
	// byte spoiled, and short noise leaning on the pattern's own bytes so that
	// near-matches and overlapping candidates turn up often.
	function automatic text_q_t random_string();
		text_q_t s;
		text_q_t p;
		int      plen;
		plen = eff_plen();
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(0, 9)) inside
				[0:4]: p = pattern_text(plen);
				[5:6]: p = pattern_text($urandom_range(1, plen));
				7: begin
					p = pattern_text(plen);
					p[$urandom_range(0, plen - 1)] = 8'($urandom_range(0, 255));
				end
				default: begin
					p.delete();
					repeat ($urandom_range(1, 3)) begin
						if ($urandom_range(0, 1) == 1) begin
							p.push_back(pat_model[8*$urandom_range(0, plen - 1) +: 8]);
						end else begin
							p.push_back(8'($urandom_range(0, 255)));
						end
					end
				end
			endcase
			foreach (p[k]) begin
				s.push_back(p[k]);
			end
		end
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Receiver: own stall pattern, plus a long hold-off on request
	// ------------------------------------------------------------------
	ready_mode_t ready_mode = RDY_ALWAYS;
	int          seg_left   = 0;
	int          hold_left  = 0;
	bit          hold_req   = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left   = $urandom_range(1, 60);
				ready_mode = ready_mode_t'($urandom_range(0, 3));
			end
			seg_left--;
			case (ready_mode)
				RDY_ALWAYS: out_ready <= 1'b1;
				RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:    out_ready <= ~out_ready;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Checker: each accepted byte against the oldest owed one
	// ------------------------------------------------------------------
	function automatic void flag_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
	                                    input logic [7:0] got);
		if (got !== want) begin
			flag_error($sformatf("%s expected 0x%02h got 0x%02h", name, want, got));
		end
	endfunction

	always @(posedge clk) begin
		text_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rewritten_q.size() == 0) begin
				flag_error($sformatf("unexpected byte 0x%02h run_last %b string_end %b",
				                     char_out, run_last, string_end));
			end else begin
				want = rewritten_q.pop_front();
				check_field("char_out",   want.ch,              char_out);
				check_field("run_last",   8'(want.run_last),    8'(run_last));
				check_field("string_end", 8'(want.string_end),  8'(string_end));
			end
		end
	end

	// Watchdog: a run that stops moving is a failure
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles, %0d bytes owed",
				         quiet_cycles, rewritten_q.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: full match, lone bytes, extreme byte values, a flush of
	// a partial match and a near miss on the last pattern byte.
	task automatic test_default_strings();
		text_q_t t;
		send_text(pattern_text(ssr_pkg::PAT_BYTES), 1'b1);
		t = {8'h00};
		send_text(t, 1'b1);
		t = {8'hFF, 8'h00, 8'hFF};
		send_text(t, 1'b1);
		send_text(pattern_text(ssr_pkg::PAT_BYTES - 1), 1'b1);
		t = pattern_text(ssr_pkg::PAT_BYTES);
		t[ssr_pkg::PAT_BYTES-1] = ~t[ssr_pkg::PAT_BYTES-1];
		send_text(t, 1'b1);
	endtask

	// Length extremes, zero and oversize lengths, data bits above each field
	task automatic test_length_extremes();
		text_q_t t;
		// all-zero pattern of length 0 (acts as 1), one-byte zero replacement
		configure(64'hFFFF_0000_0000_0000, 64'd0, 64'd0, 64'd0);
		t = {8'h00, 8'h01, 8'h00, 8'h00, 8'hFF};
		send_text(t, 1'b1);
		// all-ones everything, lengths 7 and 15 saturate to 6 and 8
		configure({ssr_pkg::CFG_W{1'b1}}, 64'd7, {ssr_pkg::CFG_W{1'b1}}, 64'd15);
		t = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		send_text(t, 1'b1);
		// single-byte pattern to full replacement: heaviest expansion
		configure({$urandom, $urandom}, 64'd1, {$urandom, $urandom}, 64'd8);
		repeat (3) send_text(random_string(), 1'b1);
		// longest pattern shrinking to one byte
		configure({$urandom, $urandom}, 64'd6, {$urandom, $urandom}, 64'd1);
		repeat (3) send_text(random_string(), 1'b1);
	endtask

	// Writes in the middle of a string: most keep the window, a length write
	// throws it away.
	task automatic test_writes_mid_string();
		text_q_t p;
		text_q_t head;
		text_q_t tail;
		configure(ssr_pkg::CFG_W'(ssr_pkg::PATTERN_RST), 64'd6, {$urandom, $urandom}, 64'd3);
		p = pattern_text(ssr_pkg::PAT_BYTES);
		head = p[0:2];
		tail = p[3:5];
		send_text(head, 1'b0);
		settle();
		write_reg(ssr_pkg::REG_REPLACE, {$urandom, $urandom});
		write_reg(ssr_pkg::REG_RLEN, 64'd5);
		write_reg(ssr_pkg::REG_PATTERN, ssr_pkg::CFG_W'(ssr_pkg::PATTERN_RST));
		send_text(tail, 1'b1); // completes the match with the new replacement
		send_text(head, 1'b0);
		settle();
		write_reg(ssr_pkg::REG_PLEN, 64'd6);
		send_text(tail, 1'b1); // only the tail comes back
	endtask

	// Long receiver hold-off while the sender keeps offering expanding items
	task automatic test_backpressure();
		text_q_t t;
		configure({$urandom, $urandom}, 64'd1, {$urandom, $urandom}, 64'd8);
		settle();
		hold_req = 1'b1;
		repeat (40) t.push_back(($urandom_range(0, 4) != 0) ? pat_model[7:0]
		                                                    : 8'($urandom_range(0, 255)));
		send_text(t, 1'b1);
		settle();
	endtask

	// Random phases: fresh settings, then a handful of random strings each
	task automatic test_random();
		int                        start;
		logic [ssr_pkg::CFG_W-1:0] pat;
		logic [7:0]                b;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: pat = {$urandom, $urandom};
				1: begin
					// one repeated byte: overlapping candidates, greedy matching
					b = 8'($urandom_range(0, 255));
					pat = {8{b}};
				end
				2: begin
					for (int k = 0; k < 8; k++) begin
						pat[8*k +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
					end
				end
				default: pat = ssr_pkg::CFG_W'(ssr_pkg::PATTERN_RST);
			endcase
			configure(pat, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			repeat ($urandom_range(3, 8)) send_text(random_string(), 1'b1);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_strings();
		test_length_extremes();
		test_writes_mid_string();
		test_backpressure();
		test_random();

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && rewritten_q.size() == 0) begin
			$display("PASS");
		end else begin
			if (rewritten_q.size() != 0) begin
				$display("%0d rewritten bytes never arrived", rewritten_q.size());
			end
			$display("FAIL");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_cell.sv
hw/rtl/ssr_serial.sv
hw/rtl/stream_substring_replace.sv
hw/rtl/ssr_checker.sv
tb/tb_stream_substring_replace.sv
